FILE: rtl/dss_pkg.sv
// Shared types, constants and helpers for the DNA site scanner.
package dss_pkg;

    localparam int MAX_SITE_BASES = 32;
    localparam int POSITION_BITS  = 31;
    localparam int CODE_BITS      = 64;
    localparam int LEN_BITS       = 6;
    localparam int CHAR_BITS      = 8;
    localparam int KIND_BITS      = 2;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // Configuration register indexes.
    localparam logic REG_PATTERN_CODE   = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    // Result kinds.
    localparam logic [KIND_BITS-1:0] KIND_SITE  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_START = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_END   = 2'd2;

    // One queued record: everything the back end needs to emit an item's results.
    typedef struct packed {
        logic                     start;
        logic                     hit;
        logic [POSITION_BITS-1:0] hit_pos;
        logic                     last;
        logic [POSITION_BITS-1:0] size;
    } dss_rec_t;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS-1:0] r;
        r = (v == POS_MAX) ? v : v + POSITION_BITS'(1);
        return r;
    endfunction

endpackage

FILE: rtl/dss_front.sv
// Front end: configuration registers, rolling window, match detection.
module dss_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_index,
    input  logic [dss_pkg::CODE_BITS-1:0]        cfg_data,
    input  logic                                 in_valid,
    input  logic [dss_pkg::CHAR_BITS-1:0]        base_char,
    input  logic                                 last_base,
    input  logic                                 q_full,
    output logic                                 push,
    output dss_pkg::dss_rec_t                    rec
);

    logic [dss_pkg::CODE_BITS-1:0]     pattern_code_reg, pattern_code_next;
    logic [dss_pkg::LEN_BITS-1:0]      pattern_length_reg, pattern_length_next;
    logic [dss_pkg::CODE_BITS-1:0]     window_reg, window_next;
    logic [dss_pkg::POSITION_BITS-1:0] wstart_reg, wstart_next;
    logic [dss_pkg::POSITION_BITS-1:0] idx_reg, idx_next;

    logic                              accept;
    logic [2:0]                        code;
    logic [dss_pkg::LEN_BITS-1:0]      len_clamp;
    logic [dss_pkg::CODE_BITS-1:0]     mask;
    logic [dss_pkg::CODE_BITS-1:0]     shifted;
    logic [dss_pkg::POSITION_BITS:0]   i_plus;
    logic [dss_pkg::POSITION_BITS:0]   span;
    logic                              full_window;
    logic                              hit;

    // Bit 2 set means the byte is not a nucleotide letter.
    function automatic logic [2:0] base_code(input logic [dss_pkg::CHAR_BITS-1:0] ch);
        logic [2:0] r;
        case (ch)
            "A", "a": r = 3'd0;
            "C", "c": r = 3'd1;
            "G", "g": r = 3'd2;
            "T", "t": r = 3'd3;
            default:  r = 3'd4;
        endcase
        return r;
    endfunction

    assign accept = in_valid && !q_full;

    always_comb
    begin
        code      = base_code(base_char);
        len_clamp = (pattern_length_reg > dss_pkg::LEN_BITS'(dss_pkg::MAX_SITE_BASES))
                  ? dss_pkg::LEN_BITS'(dss_pkg::MAX_SITE_BASES) : pattern_length_reg;
        for (int j = 0; j < dss_pkg::CODE_BITS; j++)
        begin
            mask[j] = ((j >> 1) < int'(len_clamp));
        end
        shifted     = {window_reg[dss_pkg::CODE_BITS-3:0], code[1:0]} & mask;
        i_plus      = {1'b0, idx_reg} + (dss_pkg::POSITION_BITS+1)'(1);
        span        = i_plus - {1'b0, wstart_reg};
        full_window = (len_clamp != '0) && ({1'b0, wstart_reg} <= i_plus)
                   && (span == (dss_pkg::POSITION_BITS+1)'(len_clamp));
        hit         = 1'b0;

        window_next = window_reg;
        wstart_next = wstart_reg;
        idx_next    = idx_reg;

        if (accept)
        begin
            if (idx_reg != '0)
            begin
                if (code[2])
                begin
                    window_next = '0;
                    wstart_next = dss_pkg::sat_inc(idx_reg);
                end
                else
                begin
                    window_next = shifted;
                    if (full_window)
                    begin
                        hit         = (shifted == pattern_code_reg);
                        wstart_next = dss_pkg::sat_inc(wstart_reg);
                    end
                end
            end
            if (last_base)
            begin
                window_next = '0;
                wstart_next = dss_pkg::POSITION_BITS'(1);
                idx_next    = '0;
            end
            else
            begin
                idx_next = dss_pkg::sat_inc(idx_reg);
            end
        end
    end

    always_comb
    begin
        pattern_code_next   = pattern_code_reg;
        pattern_length_next = pattern_length_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                dss_pkg::REG_PATTERN_CODE:   pattern_code_next   = cfg_data;
                dss_pkg::REG_PATTERN_LENGTH: pattern_length_next = cfg_data[dss_pkg::LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rec.start   = (idx_reg == '0);
        rec.hit     = hit;
        rec.hit_pos = wstart_reg;
        rec.last    = last_base;
        rec.size    = dss_pkg::sat_inc(idx_reg);
        push        = accept && (rec.start || hit || last_base);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_code_reg   <= '0;
            pattern_length_reg <= dss_pkg::LEN_BITS'(6);
            window_reg         <= '0;
            wstart_reg         <= dss_pkg::POSITION_BITS'(1);
            idx_reg            <= '0;
        end
        else
        begin
            pattern_code_reg   <= pattern_code_next;
            pattern_length_reg <= pattern_length_next;
            window_reg         <= window_next;
            wstart_reg         <= wstart_next;
            idx_reg            <= idx_next;
        end
    end

endmodule

FILE: rtl/dss_queue.sv
// Small register queue of result records between front and back ends.
module dss_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dss_pkg::dss_rec_t push_rec,
    input  logic              pop,
    output dss_pkg::dss_rec_t head,
    output logic              empty,
    output logic              full
);

    localparam int PTR_BITS = $clog2(dss_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(dss_pkg::QUEUE_DEPTH + 1);

    dss_pkg::dss_rec_t    slots_reg [dss_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  wr_reg, wr_next;
    logic [PTR_BITS-1:0]  rd_reg, rd_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_BITS'(dss_pkg::QUEUE_DEPTH));
    assign head    = slots_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = do_push ? ((wr_reg == PTR_BITS'(dss_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_reg + PTR_BITS'(1)) : wr_reg;
        rd_next  = do_pop  ? ((rd_reg == PTR_BITS'(dss_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_reg + PTR_BITS'(1)) : rd_reg;
        cnt_next = cnt_reg + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/dss_back.sv
// Back end: expands queued records into result beats through an output register.
module dss_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dss_pkg::dss_rec_t                    head,
    input  logic                                 empty,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [dss_pkg::POSITION_BITS-1:0]    site_position,
    output logic [dss_pkg::KIND_BITS-1:0]        result_kind,
    output logic                                 run_last
);

    // Result slots of one record, in emission order.
    localparam logic [1:0] SLOT_START    = 2'd0;
    localparam logic [1:0] SLOT_SITE     = 2'd1;
    localparam logic [1:0] SLOT_END      = 2'd2;
    localparam logic [1:0] SLOT_END_LAST = 2'd3;

    logic                              out_valid_reg, out_valid_next;
    logic [dss_pkg::POSITION_BITS-1:0] pos_reg, pos_next;
    logic [dss_pkg::KIND_BITS-1:0]     kind_reg, kind_next;
    logic                              last_reg, last_next;
    logic [1:0]                        phase_reg, phase_next;

    logic                              load;
    logic [3:0]                        present;
    logic [1:0]                        cur;
    logic                              found;
    logic                              more;

    // Slots in emission order: start sentinel, site match, first and second end sentinels.
    always_comb
    begin
        present = {head.last, head.last, head.hit, head.start};
        cur     = '0;
        found   = 1'b0;
        more    = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (!found && (k >= int'(phase_reg)) && present[k])
            begin
                cur   = 2'(k);
                found = 1'b1;
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            if (present[k] && (k > int'(cur)))
            begin
                more = 1'b1;
            end
        end
        load = !empty && (!out_valid_reg || !out_stall);
        pop  = load && !more;

        out_valid_next = out_valid_reg && out_stall;
        pos_next       = pos_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        phase_next     = phase_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            last_next      = 1'b0;
            case (cur)
                SLOT_START:
                begin
                    pos_next  = '0;
                    kind_next = dss_pkg::KIND_START;
                end
                SLOT_SITE:
                begin
                    pos_next  = head.hit_pos;
                    kind_next = dss_pkg::KIND_SITE;
                end
                SLOT_END:
                begin
                    pos_next  = head.size;
                    kind_next = dss_pkg::KIND_END;
                end
                SLOT_END_LAST:
                begin
                    pos_next  = dss_pkg::sat_inc(head.size);
                    kind_next = dss_pkg::KIND_END;
                    last_next = 1'b1;
                end
                default:
                begin
                    pos_next  = pos_reg;
                end
            endcase
            phase_next = more ? cur + 2'd1 : SLOT_START;
        end
    end

    assign out_valid     = out_valid_reg;
    assign site_position = pos_reg;
    assign result_kind   = kind_reg;
    assign run_last      = last_reg;

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

endmodule

FILE: rtl/dna_site_scanner_top.sv
// Top level of the DNA recognition-site scanner.
//
//  Channel  Direction  Handshake              Beat contents
//  in       to block   in_valid / in_stall    base_char, last_base
//  out      from block out_valid / out_stall  site_position, result_kind, run_last
//  cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; the front end updates the window and,
// if the byte has results, queues a record of them in that cycle for the back end to expand.
// The back end sends one to three beats per record from a four-entry queue, one per cycle
// while out_stall is low. in_stall rises only when that queue is full, which happens while
// beats are stalled or while bytes cause more than one beat per cycle on average.
// Reset clears the window, counters, queue and output valid, and loads pattern_length
// with 6 and pattern_code with 0.
module dna_site_scanner_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_index,
    input  logic [dss_pkg::CODE_BITS-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [dss_pkg::CHAR_BITS-1:0]        base_char,
    input  logic                                 last_base,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [dss_pkg::POSITION_BITS-1:0]    site_position,
    output logic [dss_pkg::KIND_BITS-1:0]        result_kind,
    output logic                                 run_last
);

    dss_pkg::dss_rec_t push_rec;
    dss_pkg::dss_rec_t head;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;

    // Configuration is to be written only while idle; the block does not enforce this, so writes never wait.
    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    dss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .base_char (base_char),
        .last_base (last_base),
        .q_full    (q_full),
        .push      (q_push),
        .rec       (push_rec)
    );

    dss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    dss_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (q_empty),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .site_position (site_position),
        .result_kind   (result_kind),
        .run_last      (run_last)
    );

`ifndef SYNTH
    // The front end must never push a record into a full queue.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("record pushed into full queue");

    // The back end never pops an empty queue.
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("record popped from empty queue");

    // Only the second end sentinel closes a sequence.
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && run_last) |-> (result_kind == dss_pkg::KIND_END))
        else $error("run_last on a beat that is not an end sentinel");

    // A start sentinel always reports position zero.
    a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == dss_pkg::KIND_START) |-> (site_position == '0))
        else $error("start sentinel with nonzero position");
`endif

endmodule

FILE: dv/tb_dna_site_scanner_top.sv
// Self-checking testbench for the DNA site scanner top level.
module tb_dna_site_scanner_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Clock, reset and run-length settings.
    localparam int     HALF_PERIOD   = 6;
    localparam int     RESET_CYCLES  = 7;
    // The front end decides the results of a byte in the cycle it takes it, and
    // the back end empties a four-entry queue, so SETTLE_CYCLES covers any work
    // still in flight once the last expected beat has arrived.
    localparam int     SETTLE_CYCLES = 12;
    localparam int     RANDOM_BASES  = 320;
    localparam int     IDLE_MAX      = 19;
    localparam longint CYCLE_LIMIT   = 600000;

    // Letters of the four bases, indexed by their 2-bit code.
    localparam logic [7:0] BASE_LETTER [4] = '{"A", "C", "G", "T"};
    localparam logic [7:0] LOWER_CASE_BIT  = 8'h20;
    localparam logic [2:0] NOT_A_BASE      = 3'b100;

    // One result beat as the scanner should produce it.
    typedef struct packed {
        logic [dss_pkg::POSITION_BITS-1:0] pos;
        logic [dss_pkg::KIND_BITS-1:0]     kind;
        logic                              run_last;
    } scan_result_t;

    // Clock.
    logic clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Block ports.
    logic                              rst_n;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic                              cfg_index;
    logic [dss_pkg::CODE_BITS-1:0]     cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic [dss_pkg::CHAR_BITS-1:0]     base_char;
    logic                              last_base;
    logic                              out_valid;
    logic                              out_stall;
    logic [dss_pkg::POSITION_BITS-1:0] site_position;
    logic [dss_pkg::KIND_BITS-1:0]     result_kind;
    logic                              run_last;

    dna_site_scanner_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .base_char     (base_char),
        .last_base     (last_base),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .site_position (site_position),
        .result_kind   (result_kind),
        .run_last      (run_last)
    );

    // Local scan model: its own copy of the registers and of the rolling state,
    // starting from the reset values of the block.
    logic [dss_pkg::CODE_BITS-1:0]     model_code   = '0;
    logic [dss_pkg::LEN_BITS-1:0]      model_len    = dss_pkg::LEN_BITS'(6);
    logic [dss_pkg::CODE_BITS-1:0]     window_bits  = '0;
    logic [dss_pkg::POSITION_BITS-1:0] window_first = dss_pkg::POSITION_BITS'(1);
    logic [dss_pkg::POSITION_BITS-1:0] byte_index   = '0;

    // Results predicted but not yet seen on the output channel, oldest first.
    scan_result_t pending_results[$];

    // Idle controls: the largest gap the sender leaves before a beat and the
    // largest stall the receiver holds after one. Zero gives a stretch with no idling.
    int     in_idle_max  = IDLE_MAX;
    int     out_idle_max = IDLE_MAX;
    int     stall_left   = 0;

    // Bookkeeping.
    longint cycle_count    = 0;
    int     errors         = 0;
    int     bases_sent     = 0;
    int     sequences_sent = 0;
    int     reg_writes     = 0;
    int     beats_checked  = 0;
    int     sites_seen     = 0;

    // Position increment that sticks at the largest position.
    function automatic logic [dss_pkg::POSITION_BITS-1:0] pos_step(
        input logic [dss_pkg::POSITION_BITS-1:0] v);
        return (v == dss_pkg::POS_MAX) ? v : v + dss_pkg::POSITION_BITS'(1);
    endfunction

    // Mask that keeps the low two bits per base of a site of len bases.
    function automatic logic [dss_pkg::CODE_BITS-1:0] site_mask(input int len);
        return (len >= dss_pkg::MAX_SITE_BASES) ? {dss_pkg::CODE_BITS{1'b1}}
                                                : (64'd1 << (2 * len)) - 64'd1;
    endfunction

    // 2-bit code of a letter in either case, or NOT_A_BASE for any other byte.
    function automatic logic [2:0] base_code_of(input logic [7:0] ch);
        for (int k = 0; k < 4; k++)
            if ((ch | LOWER_CASE_BIT) == (BASE_LETTER[k] | LOWER_CASE_BIT))
                return 3'(k);
        return NOT_A_BASE;
    endfunction

    // Letter for a code, upper or lower case at random.
    function automatic logic [7:0] base_letter(input logic [1:0] c);
        return BASE_LETTER[c] | ($urandom_range(0, 1) ? LOWER_CASE_BIT : 8'h00);
    endfunction

    function automatic void queue_result(input logic [dss_pkg::POSITION_BITS-1:0] pos,
                                         input logic [dss_pkg::KIND_BITS-1:0] kind,
                                         input logic fin);
        scan_result_t r;
        r.pos      = pos;
        r.kind     = kind;
        r.run_last = fin;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Advance the scan model by one accepted byte and queue the results it causes:
    // the start sentinel on the first byte, a site match when the full window equals
    // the pattern, and the two end sentinels on the last byte.
    task automatic scan_step(input logic [7:0] ch, input logic fin);
        logic [2:0]                        code;
        int                                len;
        logic [dss_pkg::POSITION_BITS:0]   next_index;
        logic [dss_pkg::POSITION_BITS-1:0] seq_size;
        if (byte_index == '0) begin
            // The first byte only opens the sequence; it never enters the window.
            queue_result('0, dss_pkg::KIND_START, 1'b0);
        end
        else begin
            code = base_code_of(ch);
            if (code == NOT_A_BASE) begin
                window_bits  = '0;
                window_first = pos_step(byte_index);
            end
            else begin
                len         = (model_len > dss_pkg::MAX_SITE_BASES) ? dss_pkg::MAX_SITE_BASES
                                                                    : int'(model_len);
                window_bits = ((window_bits << 2) | code[1:0]) & site_mask(len);
                next_index  = {1'b0, byte_index} + (dss_pkg::POSITION_BITS+1)'(1);
                if (len != 0 && window_first <= next_index
                        && next_index - window_first == len) begin
                    if (window_bits == model_code)
                        queue_result(window_first, dss_pkg::KIND_SITE, 1'b0);
                    window_first = pos_step(window_first);
                end
            end
        end
        if (fin) begin
            seq_size = pos_step(byte_index);
            queue_result(seq_size, dss_pkg::KIND_END, 1'b0);
            queue_result(pos_step(seq_size), dss_pkg::KIND_END, 1'b1);
            window_bits  = '0;
            window_first = dss_pkg::POSITION_BITS'(1);
            byte_index   = '0;
        end
        else begin
            byte_index = pos_step(byte_index);
        end
    endtask

    // Send one byte. Valid stays high after the beat is taken, so back-to-back
    // beats never lower and raise it in the same step; a gap lowers it first.
    task automatic send_base(input logic [7:0] ch, input logic fin);
        int gap;
        gap = $urandom_range(in_idle_max, 0);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        base_char <= ch;
        last_base <= fin;
        do @(posedge clk); while (in_stall);
        scan_step(ch, fin);
        bases_sent++;
    endtask

    // Send a whole sequence, marking its final byte.
    task automatic send_bytes(input logic [7:0] seq[$]);
        for (int k = 0; k < seq.size(); k++)
            send_base(seq[k], k == seq.size() - 1);
        sequences_sent++;
    endtask

    task automatic send_text(input string s);
        logic [7:0] seq[$];
        logic [7:0] ch;
        for (int k = 0; k < s.len(); k++) begin
            ch = s[k];
            seq.insert(seq.size(), ch);
        end
        send_bytes(seq);
    endtask

    // Release the input channel and hold off until every predicted beat has come,
    // then let the block settle.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [dss_pkg::CODE_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == dss_pkg::REG_PATTERN_CODE)
            model_code = data;
        else
            model_len = data[dss_pkg::LEN_BITS-1:0];
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Load a new recognition site once the block is idle, in either register order.
    task automatic set_site(input logic [dss_pkg::CODE_BITS-1:0] code,
                            input logic [dss_pkg::CODE_BITS-1:0] len_word);
        wait_for_results();
        if ($urandom_range(0, 1)) begin
            write_reg(dss_pkg::REG_PATTERN_LENGTH, len_word);
            write_reg(dss_pkg::REG_PATTERN_CODE, code);
        end
        else begin
            write_reg(dss_pkg::REG_PATTERN_CODE, code);
            write_reg(dss_pkg::REG_PATTERN_LENGTH, len_word);
        end
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("ERROR cycle %0d: %s is %0d, expected %0d", cycle_count, field, got, want);
        errors++;
    endtask

    // Compare one output beat with the oldest prediction.
    task automatic check_result();
        scan_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("beat with nothing pending, site_position", site_position, 0);
            return;
        end
        want = pending_results.pop_front();
        if (site_position !== want.pos)
            report_mismatch("site_position", site_position, want.pos);
        if (result_kind !== want.kind)
            report_mismatch("result_kind", result_kind, want.kind);
        if (run_last !== want.run_last)
            report_mismatch("run_last", run_last, want.run_last);
        beats_checked++;
        if (want.kind == dss_pkg::KIND_SITE)
            sites_seen++;
    endtask

    // Receiver: after each beat it draws a stall length; the stall runs down one
    // cycle at a time whether or not a beat is waiting, so it lands on every phase.
    always @(negedge clk) begin
        out_stall <= (stall_left > 0);
        if (stall_left > 0)
            stall_left--;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            check_result();
            stall_left = $urandom_range(out_idle_max, 0);
        end
    end

    // Watchdog for a run that hangs or loses beats.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The reset values of the registers (six bases, code zero) find the site AAAAAA.
    // The opening A is ignored, so the only hit starts at 1, never at 0.
    task automatic test_reset_defaults();
        send_text("AAAAAAA");
    endtask

    // A one-byte sequence gives the start sentinel and the ends 1 and 2.
    task automatic test_one_byte();
        send_base("T", 1'b1);
        sequences_sent++;
    endtask

    // Site GT in mixed case. Non-bases clear the window, and a site right after
    // one still matches; hits land at 1, 4 and 7.
    task automatic test_case_and_breaks();
        set_site(64'hB, 64'd2);
        send_text("NgTnGttGT");
    endtask

    // Zero length never matches, even though the empty window equals code zero.
    // The length word carries ones above its six used bits.
    task automatic test_zero_length();
        set_site(64'h0, 64'hFFFF_FFFF_FFFF_FFC0);
        send_text("AAA");
    endtask

    // A code with a bit above a one-base site matches nothing, not even A.
    task automatic test_bits_above_site();
        set_site(64'h4, 64'd1);
        send_text("xACGT");
    endtask

    // Random phases, each with its own site: lengths 1, 32, zero, above 32, and
    // codes with stray high bits among them. Most sequences are well formed with
    // the site planted whole or cut short; the rest are short or pure noise.
    task automatic test_random_sites();
        int                            phase;
        int                            start_count;
        int                            eff;
        int                            pick;
        int                            target;
        int                            cut;
        logic [dss_pkg::LEN_BITS-1:0]  len;
        logic [dss_pkg::CODE_BITS-1:0] code;
        logic [dss_pkg::CODE_BITS-1:0] len_word;
        logic [7:0]                    seq[$];
        phase       = 0;
        start_count = bases_sent;
        while (bases_sent - start_count < RANDOM_BASES || phase < 7) begin
            case (phase % 7)
                0:       len = dss_pkg::LEN_BITS'(1);
                1:       len = dss_pkg::LEN_BITS'(dss_pkg::MAX_SITE_BASES);
                2:       len = dss_pkg::LEN_BITS'($urandom_range(2, 31));
                3:       len = '0;
                4:       len = dss_pkg::LEN_BITS'($urandom_range(33, 63));
                5:       len = dss_pkg::LEN_BITS'($urandom_range(3, 12));
                default: len = dss_pkg::LEN_BITS'($urandom_range(2, 8));
            endcase
            eff  = (len > dss_pkg::MAX_SITE_BASES) ? dss_pkg::MAX_SITE_BASES : int'(len);
            code = {$urandom(), $urandom()} & site_mask(eff);
            if (phase == 1)
                code = {dss_pkg::CODE_BITS{1'b1}};
            if (phase % 7 == 5)
                code[2 * eff + $urandom_range(0, dss_pkg::CODE_BITS - 1 - 2 * eff)] = 1'b1;
            len_word = {$urandom(), $urandom()};
            len_word[dss_pkg::LEN_BITS-1:0] = len;
            set_site(code, len_word);

            repeat (2) begin
                in_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
                out_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
                seq.delete();
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    repeat ($urandom_range(1, 3)) seq.insert(seq.size(), 8'($urandom()));
                end
                else if (pick == 1) begin
                    repeat ($urandom_range(4, 30)) seq.insert(seq.size(), 8'($urandom()));
                end
                else begin
                    target = eff + $urandom_range(2, 16);
                    seq.insert(seq.size(), 8'($urandom()));
                    while (seq.size() < target) begin
                        pick = $urandom_range(0, 9);
                        if (pick <= 4) begin
                            // Whole site, or a prefix of it that breaks off.
                            cut = (pick == 4) ? $urandom_range(0, eff) : eff;
                            for (int k = 0; k < cut; k++)
                                seq.insert(seq.size(),
                                           base_letter(2'(code >> (2 * (eff - 1 - k)))));
                        end
                        else if (pick < 9) begin
                            seq.insert(seq.size(), base_letter(2'($urandom_range(0, 3))));
                        end
                        else begin
                            seq.insert(seq.size(), 8'($urandom()));
                        end
                    end
                end
                send_bytes(seq);
            end
            phase++;
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= dss_pkg::REG_PATTERN_CODE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        base_char <= '0;
        last_base <= 1'b0;
        out_stall <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_one_byte();
        test_case_and_breaks();
        test_zero_length();
        test_bits_above_site();
        test_random_sites();

        wait_for_results();
        $display("Covered %0d sequences (%0d bytes) under %0d register writes;",
                 sequences_sent, bases_sent, reg_writes);
        $display("checked %0d result beats, %0d of them site matches.", beats_checked, sites_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/dss_pkg.sv
rtl/dss_front.sv
rtl/dss_queue.sv
rtl/dss_back.sv
rtl/dna_site_scanner_top.sv
dv/tb_dna_site_scanner_top.sv
